/* src/jpp_pkg.sv */
package jpp_pkg;

   localparam int unsigned MAX_DEPTH = 7;
   localparam int unsigned DEPTH_W = 3;
   localparam int unsigned WIDTH_W = 3;
   localparam int unsigned SPACE_W = 5;

   localparam logic [WIDTH_W-1:0] WIDTH_CAP = 3'd4;
   localparam logic [WIDTH_W-1:0] WIDTH_RESET = 3'd4;
   localparam logic [DEPTH_W-1:0] DEPTH_LIMIT = 3'(MAX_DEPTH);

   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_LBRACKET = 8'h5B;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_RBRACKET = 8'h5D;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;

endpackage

/* src/json_pretty_print_stream_core.sv */
// throughput: one output byte per cycle from the expansion sequencer unless rsp stalls it;
// a dropped byte makes no output, a byte expands into at most 51 output bytes
// and the input is taken again in the cycle the previous item's last byte moves out
// reset (synchronous, active high) clears string flag, depth, space skip and all
// valid state; indent width returns to 4
module json_pretty_print_stream_core
   import jpp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_in_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_last,
   input  logic               csr_we,
   input  logic [WIDTH_W-1:0] csr_indent_width
);

   typedef enum logic [2:0] {
      PH_NL0,
      PH_SP0,
      PH_CHAR,
      PH_NL1,
      PH_SP1
   } phase_type;

   logic [WIDTH_W-1:0] width_ff;
   logic               in_string_ff, in_string_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic               skip_ff, skip_in;

   logic               job_active_ff;
   logic               job_pass_ff, job_pass_in;
   phase_type          phase_ff, phase_in, start_phase;
   logic [7:0]         job_byte_ff;
   logic [SPACE_W-1:0] job_spaces_ff, job_spaces_in;
   logic [SPACE_W-1:0] cnt_ff, cnt_in;

   logic               rsp_valid_ff;
   logic [7:0]         rsp_byte_ff;
   logic               rsp_last_ff;

   logic               accept, load_job, advance;
   logic [7:0]         cur_byte;
   logic               cur_last;
   logic [WIDTH_W-1:0] width_eff;
   logic               is_open, is_close;

   assign width_eff = (width_ff > WIDTH_CAP) ? WIDTH_CAP : width_ff;
   assign is_open = (req_in_byte == CH_LBRACE) || (req_in_byte == CH_LBRACKET) ||
                    (req_in_byte == CH_LPAREN);
   assign is_close = (req_in_byte == CH_RBRACE) || (req_in_byte == CH_RBRACKET) ||
                     (req_in_byte == CH_RPAREN);

   // decode of the incoming byte and state update
   always_comb begin
      in_string_in = in_string_ff;
      depth_in = depth_ff;
      skip_in = skip_ff;
      load_job = 1'b1;
      job_pass_in = 1'b1;
      start_phase = PH_CHAR;
      if (in_string_ff) begin
         if (req_in_byte == CH_QUOTE) begin
            in_string_in = 1'b0;
         end
      end else if (req_in_byte == CH_NEWLINE) begin
         load_job = 1'b0;
      end else if (skip_ff && (req_in_byte == CH_SPACE)) begin
         load_job = 1'b0;
      end else begin
         skip_in = 1'b0;
         if (is_open) begin
            if (depth_ff < DEPTH_LIMIT) begin
               depth_in = depth_ff + 1'b1;
            end
            job_pass_in = 1'b0;
         end else if (is_close) begin
            if (depth_ff != '0) begin
               depth_in = depth_ff - 1'b1;
            end
            job_pass_in = 1'b0;
            start_phase = PH_NL0;
         end else if (req_in_byte == CH_COMMA) begin
            job_pass_in = 1'b0;
            skip_in = 1'b1;
         end else if (req_in_byte == CH_QUOTE) begin
            in_string_in = 1'b1;
         end
      end
      job_spaces_in = SPACE_W'({2'b00, depth_in} * {2'b00, width_eff});
   end

   // byte produced by the sequencer this cycle
   always_comb begin
      cur_byte = CH_SPACE;
      cur_last = 1'b0;
      phase_in = phase_ff;
      cnt_in = cnt_ff;
      unique case (phase_ff)
         PH_NL0: begin
            cur_byte = CH_NEWLINE;
            cnt_in = job_spaces_ff;
            phase_in = (job_spaces_ff != '0) ? PH_SP0 : PH_CHAR;
         end
         PH_SP0: begin
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == SPACE_W'(1)) begin
               phase_in = PH_CHAR;
            end
         end
         PH_CHAR: begin
            cur_byte = job_byte_ff;
            cur_last = job_pass_ff;
            phase_in = PH_NL1;
         end
         PH_NL1: begin
            cur_byte = CH_NEWLINE;
            cur_last = (job_spaces_ff == '0);
            cnt_in = job_spaces_ff;
            phase_in = PH_SP1;
         end
         PH_SP1: begin
            cur_last = (cnt_ff == SPACE_W'(1));
            cnt_in = cnt_ff - 1'b1;
         end
         default: begin
            cur_last = 1'b1;
         end
      endcase
   end

   assign advance = job_active_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !job_active_ff || (advance && cur_last);
   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RESET;
         in_string_ff <= 1'b0;
         depth_ff <= '0;
         skip_ff <= 1'b0;
         job_active_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff <= PH_CHAR;
      end else begin
         if (csr_we) begin
            width_ff <= csr_indent_width;
         end
         if (accept) begin
            in_string_ff <= in_string_in;
            depth_ff <= depth_in;
            skip_ff <= skip_in;
         end
         if (accept) begin
            job_active_ff <= load_job;
            phase_ff <= start_phase;
         end else if (advance) begin
            job_active_ff <= !cur_last;
            phase_ff <= phase_in;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         job_byte_ff <= req_in_byte;
         job_pass_ff <= job_pass_in;
         job_spaces_ff <= job_spaces_in;
      end else if (advance) begin
         cnt_ff <= cnt_in;
      end
      if (advance) begin
         rsp_byte_ff <= cur_byte;
         rsp_last_ff <= cur_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_last = rsp_last_ff;

   a_depth_range: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DEPTH_LIMIT)
      else $error("nesting depth above limit");

   a_space_count: assert property (@(posedge clock) disable iff (reset)
      (job_active_ff && (phase_ff == PH_SP0 || phase_ff == PH_SP1)) |-> (cnt_ff != '0))
      else $error("space run entered with zero count");

   a_skip_outside_string: assert property (@(posedge clock) disable iff (reset)
      skip_ff |-> !in_string_ff)
      else $error("space skip set inside a string");

   a_job_loaded: assert property (@(posedge clock) disable iff (reset)
      (accept && load_job) |=> job_active_ff)
      else $error("expanding transfer not loaded");

   a_job_holds: assert property (@(posedge clock) disable iff (reset)
      (job_active_ff && !advance) |=> (job_active_ff && $stable(phase_ff)))
      else $error("sequencer moved while stalled");

endmodule

/* bench/json_pretty_print_stream_core_tb.sv */
`timescale 1ns / 100ps

module json_pretty_print_stream_core_tb;
   import jpp_pkg::*;

   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam int CYCLE_LIMIT = 600000;
   localparam int SETTLE_CYCLES = 8;
   localparam int LONG_HOLD = 400;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } text_out_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [7:0]         req_in_byte = 8'h00;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [7:0]         rsp_out_byte;
   logic               rsp_last;
   logic               csr_we = 1'b0;
   logic [WIDTH_W-1:0] csr_indent_width = WIDTH_RESET;

   // formatter state as the bench sees it
   logic [WIDTH_W-1:0] fmt_width = WIDTH_RESET;
   logic [DEPTH_W-1:0] fmt_depth = '0;
   logic               fmt_in_string = 1'b0;
   logic               fmt_skip = 1'b0;
   int                 peak_depth = 0;

   logic [7:0]   raw_bytes_q[$];
   text_out_type formatted_q[$];
   text_out_type want;

   int send_idle_pct = 0;
   int rcv_idle_pct = 0;
   int hold_asked = 0;
   int hold_served = 0;
   int hold_left = 0;
   int phase_items = 0;
   int bytes_in = 0;
   int bytes_out = 0;
   int settings_run = 1;
   int errors = 0;
   int cycle_count = 0;

   json_pretty_print_stream_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_byte      (req_in_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_last         (rsp_last),
      .csr_we           (csr_we),
      .csr_indent_width (csr_indent_width)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void put_text(input logic [7:0] b);
      text_out_type t;
      t.out_byte = b;
      t.last = 1'b0;
      formatted_q.push_back(t);
   endfunction

   function automatic void put_spaces();
      int w;
      int count;
      w = (fmt_width > WIDTH_CAP) ? int'(WIDTH_CAP) : int'(fmt_width);
      count = int'(fmt_depth) * w;
      for (int i = 0; i < count; i++) put_text(CH_SPACE);
   endfunction

   // expected output bytes for one raw byte, last flag on the final one
   function automatic void format_byte(input logic [7:0] b);
      int mark;
      mark = formatted_q.size();
      if (fmt_in_string) begin
         if (b == CH_QUOTE) fmt_in_string = 1'b0;
         put_text(b);
      end else if (b == CH_NEWLINE) begin
         // dropped, skip flag kept
      end else if (fmt_skip && b == CH_SPACE) begin
         // spaces after a comma are swallowed
      end else begin
         fmt_skip = 1'b0;
         case (b)
            CH_LBRACE, CH_LBRACKET, CH_LPAREN: begin
               if (fmt_depth < DEPTH_LIMIT) fmt_depth = fmt_depth + 1'b1;
               put_text(b);
               put_text(CH_NEWLINE);
               put_spaces();
            end
            CH_RBRACE, CH_RBRACKET, CH_RPAREN: begin
               if (fmt_depth > 0) fmt_depth = fmt_depth - 1'b1;
               put_text(CH_NEWLINE);
               put_spaces();
               put_text(b);
               put_text(CH_NEWLINE);
               put_spaces();
            end
            CH_COMMA: begin
               put_text(b);
               put_text(CH_NEWLINE);
               put_spaces();
               fmt_skip = 1'b1;
            end
            default: begin
               if (b == CH_QUOTE) fmt_in_string = 1'b1;
               put_text(b);
            end
         endcase
      end
      if (formatted_q.size() > mark) formatted_q[formatted_q.size()-1].last = 1'b1;
      if (int'(fmt_depth) > peak_depth) peak_depth = int'(fmt_depth);
   endfunction

   // input side: feeds queued raw bytes, holds a byte until its transfer
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            format_byte(req_in_byte);
            bytes_in++;
         end
         if (!(req_valid && !req_ready)) begin
            if (raw_bytes_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_in_byte <= raw_bytes_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // output side backpressure, with an occasional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         bytes_out++;
         if (formatted_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected transfer, expected none, actual byte %h last %b",
                     $time, rsp_out_byte, rsp_last);
         end else begin
            want = formatted_q.pop_front();
            if (want.out_byte !== rsp_out_byte) begin
               errors++;
               $display("%0t: out_byte expected %h actual %h", $time, want.out_byte,
                        rsp_out_byte);
            end
            if (want.last !== rsp_last) begin
               errors++;
               $display("%0t: last expected %b actual %b", $time, want.last, rsp_last);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   task automatic emit(input logic [7:0] b);
      raw_bytes_q.push_back(b);
      phase_items++;
   endtask

   task automatic gen_separator();
      emit(CH_COMMA);
      repeat ($urandom_range(2)) emit(CH_SPACE);
      if ($urandom_range(4) == 0) emit(CH_NEWLINE);
      repeat ($urandom_range(1)) emit(CH_SPACE);
   endtask

   task automatic gen_string();
      int len;
      int pick;
      logic [7:0] c;
      len = $urandom_range(5);
      emit(CH_QUOTE);
      for (int i = 0; i < len; i++) begin
         pick = $urandom_range(9);
         if (pick < 6) c = 8'h61 + 8'($urandom_range(25));
         else if (pick == 6) c = CH_LBRACE + 8'($urandom_range(2));
         else if (pick == 7) c = ($urandom_range(1) != 0) ? CH_COMMA : CH_NEWLINE;
         else c = 8'($urandom_range(255));
         if (c == CH_QUOTE) c = CH_SPACE;
         emit(c);
      end
      emit(CH_QUOTE);
   endtask

   // well formed value with random content, nesting past the depth limit at times
   task automatic gen_value(input int level);
      int kind;
      int n;
      logic [7:0] open_c;
      logic [7:0] close_c;
      kind = (level >= 9) ? 4 + $urandom_range(1) : $urandom_range(5);
      case (kind)
         0, 1: begin
            emit(CH_LBRACE);
            n = $urandom_range(3);
            for (int i = 0; i < n; i++) begin
               if (i > 0) gen_separator();
               gen_string();
               emit(CH_COLON);
               if ($urandom_range(1) != 0) emit(CH_SPACE);
               gen_value(level + 1);
            end
            emit(CH_RBRACE);
         end
         2, 3: begin
            open_c = ($urandom_range(5) == 0) ? CH_LPAREN : CH_LBRACKET;
            close_c = (open_c == CH_LPAREN) ? CH_RPAREN : CH_RBRACKET;
            emit(open_c);
            n = $urandom_range(3);
            for (int i = 0; i < n; i++) begin
               if (i > 0) gen_separator();
               gen_value(level + 1);
            end
            emit(close_c);
         end
         4: gen_string();
         default: begin
            n = 1 + $urandom_range(3);
            for (int i = 0; i < n; i++) emit(8'h30 + 8'($urandom_range(9)));
         end
      endcase
   endtask

   task automatic gen_noise();
      int pick;
      pick = $urandom_range(5);
      case (pick)
         0: emit(CH_RBRACE + 8'($urandom_range(0)));
         1: emit(($urandom_range(1) != 0) ? CH_RBRACKET : CH_RPAREN);
         2: emit(CH_QUOTE);
         3: emit(CH_SPACE);
         default: emit(8'($urandom_range(255)));
      endcase
   endtask

   task automatic gen_directed();
      // run up past the depth limit
      repeat (8) emit(CH_LBRACKET);
      emit(8'h00);
      emit(8'hFF);
      // comma then spaces, a newline in between keeps them swallowed
      emit(CH_COMMA);
      emit(CH_SPACE);
      emit(CH_NEWLINE);
      emit(CH_SPACE);
      emit(CH_LPAREN);
      // string content passes through untouched
      emit(CH_QUOTE);
      emit(CH_LBRACE);
      emit(CH_COMMA);
      emit(CH_NEWLINE);
      emit(8'hFF);
      emit(CH_QUOTE);
      emit(CH_SPACE);
      // unwind and keep closing below zero
      emit(CH_RBRACE);
      emit(CH_RPAREN);
      repeat (7) emit(CH_RBRACKET);
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (raw_bytes_q.size() > 0 || req_valid || formatted_q.size() > 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_width(input logic [WIDTH_W-1:0] w);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_indent_width <= w;
      @(posedge clock);
      csr_we <= 1'b0;
      fmt_width = w;
      settings_run++;
   endtask

   task automatic fill_random(input int target);
      while (phase_items < target) begin
         if ($urandom_range(3) != 0) gen_value(0);
         else gen_noise();
      end
   endtask

   task automatic run_phase(input int target, input bit long_hold, input bit mid_pause);
      phase_items = 0;
      if (mid_pause) begin
         fill_random(target / 2);
         wait_drained();
      end
      fill_random(target);
      if (long_hold) hold_asked <= hold_asked + 1;
      wait_drained();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 9;
      rcv_idle_pct = 82;
      gen_directed();
      wait_drained();
      run_phase(35, 1'b1, 1'b0);
      write_width(3'd1);
      run_phase(40, 1'b0, 1'b0);

      send_idle_pct = 82;
      rcv_idle_pct = 9;
      write_width(3'd7);
      run_phase(40, 1'b0, 1'b0);
      write_width(3'd0);
      run_phase(40, 1'b1, 1'b0);

      send_idle_pct = 0;
      rcv_idle_pct = 0;
      write_width(3'd2);
      run_phase(40, 1'b0, 1'b1);
      write_width(3'd4);
      run_phase(40, 1'b0, 1'b0);
      write_width(3'd3);
      run_phase(40, 1'b0, 1'b0);

      wait_drained();
      $display("covered %0d input bytes and %0d formatted bytes", bytes_in, bytes_out);
      $display("over %0d indent widths, deepest nesting reached %0d", settings_run,
               peak_depth);
      if (errors == 0 && formatted_q.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
